>>> hw/rtl/lbct_pkg.sv
package lbct_pkg;

    // Fixed geometry of the directory; the widths of the result fields follow from it.
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int BLOCK_W    = ADDR_W - PAGE_SHIFT;
    localparam int STATUS_W   = 3;
    localparam int REQ_W      = 2;

    // Capacity after reset.
    localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(NUM_SLOTS);

    typedef enum logic [REQ_W-1:0] {
        REQ_GET   = 2'd0,
        REQ_DIRTY = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_MISS        = 3'd1,
        ST_MARKED      = 3'd2,
        ST_ABSENT      = 3'd3,
        ST_MISALIGNED  = 3'd4,
        ST_FLUSHED     = 3'd5,
        ST_FLUSH_EMPTY = 3'd6
    } t_status;

    // One result as it travels on the output data bus, lowest field last.
    typedef struct packed {
        logic [SLOT_W-1:0]   wb_slot;
        logic [BLOCK_W-1:0]  wb_block;
        logic                wb_valid;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

>>> hw/rtl/lru_block_cache_tags.sv
// Get and mark-dirty: the result follows the tag walk, which reads one tag a cycle
// through a single compare unit, and then the done state.
// Misaligned requests and empty-cache flushes go straight to the done state.
// Flush: the rank map walk, then a read and an emit state per released entry.
// One request is in work at a time; a pending result may wait on the output.
// Synchronous active-low reset empties the directory and sets the capacity to 16.
module lru_block_cache_tags
    import lbct_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Capacity register
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    // Request stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [ADDR_W-1:0]   i_s_axis_tdata,  // [47:0] byte_address
    input  logic [REQ_W-1:0]    i_s_axis_tuser,  // [1:0] req_type
    // Result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [2:0] status, [6:3] slot, [7] writeback_valid, [43:8] writeback_block,
    // [47:44] writeback_slot
    output logic [RESULT_W-1:0] o_m_axis_tdata,
    output logic                o_m_axis_tlast
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_DONE    = 6'b000100,
        S_FL_MAP  = 6'b001000,
        S_FL_RD   = 6'b010000,
        S_FL_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_cfg, n_cfg;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    logic [SLOT_W-1:0] r_rank [NUM_SLOTS];
    logic [SLOT_W-1:0] n_rank [NUM_SLOTS];
    logic [SLOT_W-1:0] r_map [NUM_SLOTS];
    logic [SLOT_W-1:0] n_map [NUM_SLOTS];

    // Walk counter and compare stage
    logic [SLOT_W:0]   r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0] r_k, n_k;

    // Latched request
    t_req              r_req, n_req;
    logic [BLOCK_W-1:0] r_blk, n_blk;
    logic              r_misal, n_misal;

    // Walk findings
    logic              r_hit_f, n_hit_f;
    logic [SLOT_W-1:0] r_hit_idx, n_hit_idx;
    logic [SLOT_W-1:0] r_hit_rank, n_hit_rank;
    logic              r_vic_f, n_vic_f;
    logic [SLOT_W-1:0] r_vic_idx, n_vic_idx;
    logic [BLOCK_W-1:0] r_vic_tag, n_vic_tag;
    logic              r_vic_dirty, n_vic_dirty;
    logic              r_free_f, n_free_f;
    logic [SLOT_W-1:0] r_free_idx, n_free_idx;

    // Output register
    logic              r_o_tvalid, n_o_tvalid;
    t_result           r_o_data, n_o_data;
    logic              r_o_last, n_o_last;

    // Tag memory
    logic [BLOCK_W-1:0] tag_mem [NUM_SLOTS];
    logic [BLOCK_W-1:0] r_tag_q;
    logic               tag_we;
    logic [SLOT_W-1:0]  tag_wa;
    logic [SLOT_W-1:0]  tag_ra;

    // Miss bookkeeping
    logic [COUNT_W-1:0] cap;
    logic               evict;
    logic [SLOT_W-1:0]  new_slot;
    logic [SLOT_W-1:0]  fl_slot;
    logic               s_xfer;
    logic               out_free;

    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_tvalid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

    // Effective capacity: zero acts as one, anything above the slot count as full.
    assign cap = (r_cfg == '0) ? COUNT_W'(1) :
                 ((r_cfg > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS) : r_cfg);
    assign evict = (r_count >= cap) && r_vic_f;
    // The new block takes the lowest free slot once the victim has been released.
    assign new_slot = (evict && (!r_free_f || (r_vic_idx < r_free_idx))) ? r_vic_idx :
                      (r_free_f ? r_free_idx : '0);
    assign fl_slot  = r_map[r_k];

    assign tag_ra = (r_state == S_SCAN) ? r_idx[SLOT_W-1:0] : fl_slot;
    assign tag_wa = new_slot;

    // Tag storage with registered read.
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[tag_wa] <= r_blk;
        end
        r_tag_q <= tag_mem[tag_ra];
    end

    // Sequencer and directory update.
    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_count     = r_count;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_rank      = r_rank;
        n_map       = r_map;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_idx[SLOT_W-1:0];
        n_k         = r_k;
        n_req       = r_req;
        n_blk       = r_blk;
        n_misal     = r_misal;
        n_hit_f     = r_hit_f;
        n_hit_idx   = r_hit_idx;
        n_hit_rank  = r_hit_rank;
        n_vic_f     = r_vic_f;
        n_vic_idx   = r_vic_idx;
        n_vic_tag   = r_vic_tag;
        n_vic_dirty = r_vic_dirty;
        n_free_f    = r_free_f;
        n_free_idx  = r_free_idx;
        n_o_tvalid  = r_o_tvalid && !i_m_axis_tready;
        n_o_data    = r_o_data;
        n_o_last    = r_o_last;
        tag_we      = 1'b0;

        if (i_cfg_we) begin
            n_cfg = i_cfg_wdata;
        end

        // Walk issue, shared by the tag walk and the flush rank map walk.
        if ((r_state == S_SCAN || r_state == S_FL_MAP) && r_idx < (SLOT_W+1)'(NUM_SLOTS)) begin
            n_cmp_vld = 1'b1;
            n_cmp_idx = r_idx[SLOT_W-1:0];
            n_idx     = r_idx + (SLOT_W+1)'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_req      = t_req'(i_s_axis_tuser);
                    n_blk      = i_s_axis_tdata[ADDR_W-1:PAGE_SHIFT];
                    n_misal    = (i_s_axis_tdata[PAGE_SHIFT-1:0] != '0);
                    n_idx      = '0;
                    n_hit_f    = 1'b0;
                    n_vic_f    = 1'b0;
                    n_free_f   = 1'b0;
                    unique case (t_req'(i_s_axis_tuser))
                        REQ_GET, REQ_DIRTY: begin
                            n_state = (i_s_axis_tdata[PAGE_SHIFT-1:0] != '0) ? S_DONE : S_SCAN;
                        end
                        REQ_FLUSH: begin
                            n_misal = 1'b0;
                            n_state = (r_count == '0) ? S_DONE : S_FL_MAP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // One entry a cycle through the compare unit.
                if (r_cmp_vld) begin
                    if (r_valid[r_cmp_idx] && r_tag_q == r_blk && !r_hit_f) begin
                        n_hit_f    = 1'b1;
                        n_hit_idx  = r_cmp_idx;
                        n_hit_rank = r_rank[r_cmp_idx];
                    end
                    if (r_valid[r_cmp_idx] &&
                        {1'b0, r_rank[r_cmp_idx]} == r_count - COUNT_W'(1)) begin
                        n_vic_f     = 1'b1;
                        n_vic_idx   = r_cmp_idx;
                        n_vic_tag   = r_tag_q;
                        n_vic_dirty = r_dirty[r_cmp_idx];
                    end
                    if (!r_valid[r_cmp_idx] && !r_free_f) begin
                        n_free_f   = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_o_tvalid = 1'b1;
                    n_o_last   = 1'b1;
                    n_o_data   = '0;
                    n_state    = S_IDLE;
                    if (r_misal) begin
                        n_o_data.status = ST_MISALIGNED;
                    end else if (r_req == REQ_FLUSH) begin
                        n_o_data.status = ST_FLUSH_EMPTY;
                    end else if (r_req == REQ_DIRTY) begin
                        if (r_hit_f) begin
                            n_dirty[r_hit_idx] = 1'b1;
                            n_o_data.status    = ST_MARKED;
                            n_o_data.slot      = r_hit_idx;
                        end else begin
                            n_o_data.status = ST_ABSENT;
                        end
                    end else if (r_hit_f) begin
                        // Hit: entries more recent than the hit age by one.
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (r_valid[i] && r_rank[i] < r_hit_rank) begin
                                n_rank[i] = r_rank[i] + SLOT_W'(1);
                            end
                        end
                        n_rank[r_hit_idx] = '0;
                        n_o_data.status   = ST_HIT;
                        n_o_data.slot     = r_hit_idx;
                    end else begin
                        // Miss: release the oldest if full, then insert as most recent.
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (r_valid[i] && !(evict && SLOT_W'(i) == r_vic_idx)) begin
                                n_rank[i] = r_rank[i] + SLOT_W'(1);
                            end
                        end
                        if (evict) begin
                            n_valid[r_vic_idx] = 1'b0;
                            n_dirty[r_vic_idx] = 1'b0;
                            n_rank[r_vic_idx]  = '0;
                            if (r_vic_dirty) begin
                                n_o_data.wb_valid = 1'b1;
                                n_o_data.wb_block = r_vic_tag;
                                n_o_data.wb_slot  = r_vic_idx;
                            end
                        end
                        n_valid[new_slot] = 1'b1;
                        n_dirty[new_slot] = 1'b0;
                        n_rank[new_slot]  = '0;
                        tag_we            = 1'b1;
                        n_count = r_count - (evict ? COUNT_W'(1) : '0) + COUNT_W'(1);
                        n_o_data.status = ST_MISS;
                        n_o_data.slot   = new_slot;
                    end
                end
            end

            S_FL_MAP: begin
                // Invert the ranks: slot held at each recency position.
                if (r_cmp_vld) begin
                    if (r_valid[r_cmp_idx]) begin
                        n_map[r_rank[r_cmp_idx]] = r_cmp_idx;
                    end
                    if (r_cmp_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        n_k     = SLOT_W'(r_count - COUNT_W'(1));
                        n_state = S_FL_RD;
                    end
                end
            end

            S_FL_RD: begin
                n_state = S_FL_EMIT;
            end

            S_FL_EMIT: begin
                // Release entries from least recent to most recent.
                if (out_free) begin
                    n_o_tvalid        = 1'b1;
                    n_o_last          = (r_k == '0);
                    n_o_data          = '0;
                    n_o_data.status   = ST_FLUSHED;
                    n_o_data.slot     = fl_slot;
                    if (r_dirty[fl_slot]) begin
                        n_o_data.wb_valid = 1'b1;
                        n_o_data.wb_block = r_tag_q;
                        n_o_data.wb_slot  = fl_slot;
                    end
                    n_valid[fl_slot] = 1'b0;
                    n_dirty[fl_slot] = 1'b0;
                    if (r_k == '0) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            n_rank[i] = '0;
                        end
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k - SLOT_W'(1);
                        n_state = S_FL_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= CAP_RESET;
            r_count    <= '0;
            r_valid    <= '0;
            r_dirty    <= '0;
            r_cmp_vld  <= 1'b0;
            r_o_tvalid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_cfg      <= n_cfg;
            r_count    <= n_count;
            r_valid    <= n_valid;
            r_dirty    <= n_dirty;
            r_cmp_vld  <= n_cmp_vld;
            r_o_tvalid <= n_o_tvalid;
            r_rank     <= n_rank;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_map       <= n_map;
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_k         <= n_k;
        r_req       <= n_req;
        r_blk       <= n_blk;
        r_misal     <= n_misal;
        r_hit_f     <= n_hit_f;
        r_hit_idx   <= n_hit_idx;
        r_hit_rank  <= n_hit_rank;
        r_vic_f     <= n_vic_f;
        r_vic_idx   <= n_vic_idx;
        r_vic_tag   <= n_vic_tag;
        r_vic_dirty <= n_vic_dirty;
        r_free_f    <= n_free_f;
        r_free_idx  <= n_free_idx;
        r_o_data    <= n_o_data;
        r_o_last    <= n_o_last;
    end

endmodule

>>> verif/lru_block_cache_tags_tb.sv
`timescale 1ns / 1ps

module lru_block_cache_tags_tb;
    import lbct_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    // Longest request: a flush's rank walk, then a read and an emit per released entry.
    localparam int SETTLE_CYCLES  = 60;
    localparam int POOL_SIZE      = 24;
    localparam int MAX_REPORTS    = 10;

    // One expected result of a request, field by field.
    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic               wb_valid;
        logic [BLOCK_W-1:0] wb_block;
        logic [SLOT_W-1:0]  wb_slot;
        logic               last;
    } t_cache_result;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [COUNT_W-1:0]  cfg_wdata = '0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [ADDR_W-1:0]   req_addr  = '0;
    logic [REQ_W-1:0]    req_kind  = REQ_GET;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [RESULT_W-1:0] res_data;
    logic                res_last;

    // Shadow of the directory, kept in step with every accepted request.
    logic [BLOCK_W-1:0]  tag_q   [NUM_SLOTS];
    bit                  valid_q [NUM_SLOTS];
    bit                  dirty_q [NUM_SLOTS];
    int                  rank_q  [NUM_SLOTS];
    int                  occupancy;
    logic [COUNT_W-1:0]  capacity_reg;

    t_cache_result       expected_results[$];
    logic [BLOCK_W-1:0]  block_pool[POOL_SIZE];

    int                  fail_count     = 0;
    int                  quiet_cycles   = 0;
    int                  sender_idle_pct = 0;
    int                  res_stall_pct  = 0;

    lru_block_cache_tags dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_addr),
        .i_s_axis_tuser  (req_kind),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tlast  (res_last)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge clk) begin
        res_ready <= ($urandom_range(0, 99) >= res_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Directory predictor
    // ---------------------------------------------------------------------

    function automatic t_cache_result make_result(t_status status, int slot, bit wb_valid,
                                                  logic [BLOCK_W-1:0] wb_block, int wb_slot,
                                                  bit last);
        t_cache_result r;
        r.status   = status;
        r.slot     = SLOT_W'(slot);
        r.wb_valid = wb_valid;
        r.wb_block = wb_block;
        r.wb_slot  = SLOT_W'(wb_slot);
        r.last     = last;
        return r;
    endfunction

    // Least recently used valid entry, or -1 when the directory is empty.
    function automatic int lru_victim();
        int best;
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (valid_q[i] && (best < 0 || rank_q[i] > rank_q[best])) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void reset_directory();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_q[i]   = '0;
            valid_q[i] = 1'b0;
            dirty_q[i] = 1'b0;
            rank_q[i]  = 0;
        end
        occupancy    = 0;
        capacity_reg = CAP_RESET;
    endfunction

    // Applies one accepted request to the shadow directory and queues its results.
    function automatic void predict_request(t_req kind, logic [ADDR_W-1:0] addr);
        logic [BLOCK_W-1:0] blk;
        int                 hit;
        int                 victim;
        int                 next;
        int                 free_slot;
        int                 eff_cap;
        int                 old_rank;
        bit                 wbv;
        logic [BLOCK_W-1:0] wbb;
        int                 wbs;

        if (kind == REQ_NONE) begin
            return;
        end

        // Flush releases entries oldest first; the address plays no part.
        if (kind == REQ_FLUSH) begin
            victim = lru_victim();
            if (victim < 0) begin
                expected_results.push_back(make_result(ST_FLUSH_EMPTY, 0, 1'b0, '0, 0, 1'b1));
            end
            while (victim >= 0) begin
                wbv = dirty_q[victim];
                wbb = wbv ? tag_q[victim] : '0;
                valid_q[victim] = 1'b0;
                dirty_q[victim] = 1'b0;
                next = lru_victim();
                expected_results.push_back(make_result(ST_FLUSHED, victim, wbv, wbb,
                                                       wbv ? victim : 0, next < 0));
                victim = next;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                rank_q[i] = 0;
            end
            occupancy = 0;
            return;
        end

        if (addr[PAGE_SHIFT-1:0] != '0) begin
            expected_results.push_back(make_result(ST_MISALIGNED, 0, 1'b0, '0, 0, 1'b1));
            return;
        end

        blk = addr[ADDR_W-1:PAGE_SHIFT];
        hit = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (valid_q[i] && tag_q[i] == blk) begin
                hit = i;
            end
        end

        if (kind == REQ_DIRTY) begin
            if (hit < 0) begin
                expected_results.push_back(make_result(ST_ABSENT, 0, 1'b0, '0, 0, 1'b1));
            end else begin
                dirty_q[hit] = 1'b1;
                expected_results.push_back(make_result(ST_MARKED, hit, 1'b0, '0, 0, 1'b1));
            end
            return;
        end

        // Hit: entries more recent than this one age by one step.
        if (hit >= 0) begin
            old_rank = rank_q[hit];
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (valid_q[i] && rank_q[i] < old_rank) begin
                    rank_q[i]++;
                end
            end
            rank_q[hit] = 0;
            expected_results.push_back(make_result(ST_HIT, hit, 1'b0, '0, 0, 1'b1));
            return;
        end

        // Miss: out-of-range capacities are clamped, and at most one entry is evicted.
        eff_cap = int'(capacity_reg);
        if (eff_cap == 0) begin
            eff_cap = 1;
        end
        if (eff_cap > NUM_SLOTS) begin
            eff_cap = NUM_SLOTS;
        end
        wbv = 1'b0;
        wbb = '0;
        wbs = 0;
        if (occupancy >= eff_cap) begin
            victim = lru_victim();
            if (victim >= 0) begin
                if (dirty_q[victim]) begin
                    wbv = 1'b1;
                    wbb = tag_q[victim];
                    wbs = victim;
                end
                valid_q[victim] = 1'b0;
                dirty_q[victim] = 1'b0;
                rank_q[victim]  = 0;
                if (occupancy > 0) begin
                    occupancy--;
                end
            end
        end

        free_slot = 0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!valid_q[i]) begin
                free_slot = i;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (valid_q[i]) begin
                rank_q[i]++;
            end
        end
        tag_q[free_slot]   = blk;
        valid_q[free_slot] = 1'b1;
        dirty_q[free_slot] = 1'b0;
        rank_q[free_slot]  = 0;
        occupancy++;
        expected_results.push_back(make_result(ST_MISS, free_slot, wbv, wbb, wbs, 1'b1));
    endfunction

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    function automatic void note_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, what);
        end
    endfunction

    // Each result transfer is compared with the oldest outstanding expectation.
    always @(posedge clk) begin : check_results
        t_result       got;
        t_cache_result want;
        if (rst_n && res_valid && res_ready) begin
            got = t_result'(res_data);
            if (expected_results.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d slot %0d last %0b",
                                       got.status, got.slot, res_last));
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.wb_valid !== want.wb_valid || got.wb_block !== want.wb_block ||
                    got.wb_slot !== want.wb_slot || res_last !== want.last) begin
                    note_failure($sformatf({"mismatch: expected status %0d slot %0d wb %0b ",
                                            "block %h wb_slot %0d last %0b, got status %0d ",
                                            "slot %0d wb %0b block %h wb_slot %0d last %0b"},
                                           want.status, want.slot, want.wb_valid,
                                           want.wb_block, want.wb_slot, want.last,
                                           got.status, got.slot, got.wb_valid,
                                           got.wb_block, got.wb_slot, res_last));
                end
            end
        end
    end

    // Ends the run when neither side has made a transfer for too long.
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** lru_block_cache_tags: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [ADDR_W-1:0] block_addr(logic [BLOCK_W-1:0] blk);
        return {blk, {PAGE_SHIFT{1'b0}}};
    endfunction

    function automatic logic [BLOCK_W-1:0] random_block();
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        return r64[BLOCK_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer,
    // leaving the valid high so that back-to-back requests need no gap.
    task automatic send_request(input t_req kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_addr  <= addr;
        do begin
            @(posedge clk);
        end while (!req_ready);
        predict_request(kind, addr);
        @(negedge clk);
    endtask

    // Holds requests back until every result is in and the block has gone quiet.
    task automatic settle_idle();
        req_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we       <= 1'b0;
        capacity_reg = value;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Every request kind, address extremes and the error answers.
    task automatic test_basic_requests();
        logic [BLOCK_W-1:0] top_blk;
        top_blk = '1;
        send_request(REQ_FLUSH, '0);
        send_request(REQ_GET, '0);
        send_request(REQ_GET, block_addr(top_blk));
        send_request(REQ_GET, '0);
        send_request(REQ_DIRTY, block_addr(top_blk));
        send_request(REQ_DIRTY, block_addr(BLOCK_W'(5)));
        send_request(REQ_GET, ADDR_W'(1));
        send_request(REQ_DIRTY, ADDR_W'(12'hFFF));
        send_request(REQ_NONE, '1);
        send_request(REQ_FLUSH, '1);
        settle_idle();
    endtask

    // A capacity of zero acts as one: each miss evicts the previous block.
    task automatic test_capacity_floor();
        write_capacity(COUNT_W'(0));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'h123456789)));
        send_request(REQ_DIRTY, block_addr(BLOCK_W'(36'h123456789)));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'hABCDEF012)));
        settle_idle();
    endtask

    // Lowering the capacity below the occupancy evicts only one entry per miss.
    task automatic test_capacity_lowered();
        write_capacity(COUNT_W'(NUM_SLOTS));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'h000000011)));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'h000000022)));
        settle_idle();
        write_capacity(COUNT_W'(1));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'h000000033)));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'h000000022)));
        send_request(REQ_GET, block_addr(BLOCK_W'(36'h000000044)));
        send_request(REQ_FLUSH, '0);
        settle_idle();
    endtask

    // Mostly gets and mark-dirty requests on a small set of blocks so that hits,
    // evictions and dirty writebacks recur, with errors and flushes mixed in.
    task automatic run_random_phase(input logic [COUNT_W-1:0] capacity, input int idle_pct,
                                    input int stall_pct, input int item_count);
        int                 sent;
        int                 pick;
        logic [BLOCK_W-1:0] blk;
        write_capacity(capacity);
        sender_idle_pct = idle_pct;
        res_stall_pct   = stall_pct;
        sent = 0;
        while (sent < item_count) begin
            pick = $urandom_range(0, 99);
            blk  = block_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 52) begin
                send_request(REQ_GET, block_addr(blk));
            end else if (pick < 72) begin
                send_request(REQ_DIRTY, block_addr(blk));
            end else if (pick < 77) begin
                send_request(REQ_FLUSH, {random_block(), 12'($urandom)});
            end else if (pick < 83) begin
                send_request(REQ_GET, {blk, 12'($urandom_range(1, 4095))});
            end else if (pick < 87) begin
                send_request(REQ_DIRTY, {random_block(), 12'($urandom_range(1, 4095))});
            end else if (pick < 92) begin
                send_request(REQ_GET, block_addr(random_block()));
            end else if (pick < 95) begin
                send_request(REQ_DIRTY, block_addr(random_block()));
            end else begin
                send_request(REQ_NONE, {random_block(), 12'($urandom)});
            end
            if (pick < 95) begin
                sent++;
            end
        end
        settle_idle();
    endtask

    task automatic test_random_traffic();
        block_pool[0] = '0;
        block_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            block_pool[i] = random_block();
        end
        run_random_phase(COUNT_W'(31), 0, 0, 28);
        run_random_phase(COUNT_W'(NUM_SLOTS), 63, 0, 28);
        run_random_phase(COUNT_W'(4), 0, 63, 28);
        run_random_phase(COUNT_W'(1), 22, 22, 26);
        run_random_phase(COUNT_W'(0), 0, 0, 26);
        run_random_phase(COUNT_W'(17), 63, 0, 28);
        run_random_phase(COUNT_W'(2), 0, 63, 28);
        run_random_phase(COUNT_W'(8), 22, 22, 28);
    endtask

    initial begin
        reset_directory();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basic_requests();
        test_capacity_floor();
        test_capacity_lowered();
        test_random_traffic();

        settle_idle();
        if (fail_count == 0) begin
            $display("** lru_block_cache_tags: PASSED **");
        end else begin
            $display("** lru_block_cache_tags: FAILED **");
        end
        $finish;
    end

endmodule
